@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Every check runs on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check: prop may use |-> or |=>
`define CQS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Invariant: expr must hold on every clock edge
`define CQS_INVARIANT(lbl, expr, msg) \
   `CQS_ASSERT(lbl, 1'b1 |-> (expr), msg)

`endif

@@ rtl/core/cqs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cqs_pkg;

   // Ring geometry
   localparam int DEPTH    = 8;
   localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int SLOT_W   = 3;
   localparam int SHOW_MAX = 8;
   localparam int SHOW_LIM = (DEPTH < SHOW_MAX) ? DEPTH : SHOW_MAX;

   // Operation codes of a request
   typedef enum logic [1:0] {
      KIND_ENQ     = 2'd0,
      KIND_DEQ     = 2'd1,
      KIND_SEARCH  = 2'd2,
      KIND_DISPLAY = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Where the result data word comes from
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_MEM,
      SRC_KEY
   } src_type;

   // Controller to datapath
   typedef struct packed {
      logic       take;
      logic       walk_load;
      logic       walk_adv;
      logic       enq_write;
      logic       deq;
      logic       rsp_load;
      status_type rsp_status;
      src_type    rsp_src;
      logic       rsp_slot_en;
      logic       rsp_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     hit;
      logic     walk_last;
      logic     rsp_free;
   } stat_type;

   // Next slot around the ring
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Low bits of a slot index for the result port
   function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      logic [SLOT_W-1:0] s;
      s = '0;
      for (int i = 0; i < SLOT_W; i++) begin
         if (i < PTR_W) begin
            s[i] = p[i];
         end
      end
      slot_of = s;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/cqs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqs_ctrl
   import cqs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_WALK
   } state_type;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = ST_OK;
      cmd.rsp_src    = SRC_NONE;
      case (state_ff)
         S_IDLE: begin
            // keep the walk pointer parked on the head
            cmd.walk_load = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.kind == KIND_ENQ) begin
               if (stat.rsp_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_last   = 1'b1;
                  cmd.rsp_status = stat.full ? ST_FULL : ST_OK;
                  cmd.enq_write  = !stat.full;
                  state_in       = S_IDLE;
               end
            end else if (stat.empty) begin
               if (stat.rsp_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_last   = 1'b1;
                  cmd.rsp_status = ST_EMPTY;
                  state_in       = S_IDLE;
               end
            end else if (stat.kind == KIND_DEQ) begin
               if (stat.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  cmd.rsp_src  = SRC_MEM;
                  cmd.deq      = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (stat.kind == KIND_SEARCH) begin
               if (stat.hit) begin
                  if (stat.rsp_free) begin
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_last    = 1'b1;
                     cmd.rsp_src     = SRC_KEY;
                     cmd.rsp_slot_en = 1'b1;
                     state_in        = S_IDLE;
                  end
               end else if (stat.walk_last) begin
                  if (stat.rsp_free) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_last   = 1'b1;
                     cmd.rsp_status = ST_NOTFOUND;
                     state_in       = S_IDLE;
                  end
               end else begin
                  cmd.walk_adv = 1'b1;
               end
            end else begin
               // display: one result per held word
               if (stat.rsp_free) begin
                  cmd.rsp_load    = 1'b1;
                  cmd.rsp_last    = stat.walk_last;
                  cmd.rsp_src     = SRC_MEM;
                  cmd.rsp_slot_en = 1'b1;
                  if (stat.walk_last) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.walk_adv = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/cqs_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cqs_dpath
   import cqs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic        [1:0]        req_kind,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     rsp_stall,
   output logic                          rsp_valid,
   output logic             [1:0]        rsp_status,
   output logic signed      [DATA_W-1:0] rsp_data,
   output logic             [SLOT_W-1:0] rsp_slot,
   output logic                          rsp_last,
   input  wire cmd_type                  cmd,
   output stat_type                      stat
);

   kind_type                kind_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PTR_W-1:0]        walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        limit;
   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] mem_q;
   logic                    rsp_valid_ff;
   logic                    rsp_free;
   logic signed [DATA_W-1:0] rsp_data_in;

   // Latched request
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff  <= kind_type'(req_kind);
         value_ff <= req_value;
      end
   end

   // Ring pointers and fill count
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (cmd.enq_write) begin
         tail_in = next_slot(tail_ff);
         cnt_in  = cnt_ff + CNT_W'(1);
      end
      if (cmd.deq) begin
         head_in = next_slot(head_ff);
         cnt_in  = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Walk pointer; the memory always reads at its next value
   always_comb begin
      walk_ptr_in = walk_ptr_ff;
      idx_in      = idx_ff;
      if (cmd.walk_load) begin
         walk_ptr_in = head_ff;
         idx_in      = '0;
      end else if (cmd.walk_adv) begin
         walk_ptr_in = next_slot(walk_ptr_ff);
         idx_in      = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      walk_ptr_ff <= walk_ptr_in;
      idx_ff      <= idx_in;
   end

   // Word store, registered read
   always_ff @(posedge clock) begin
      if (cmd.enq_write) begin
         mem[tail_ff] <= value_ff;
      end
      mem_q <= mem[walk_ptr_in];
   end

   // Walk ends at the held count, display capped at eight words
   assign limit = (kind_ff == KIND_DISPLAY && cnt_ff > CNT_W'(SHOW_LIM)) ?
                  CNT_W'(SHOW_LIM) : cnt_ff;

   // Output register
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.rsp_src)
         SRC_MEM: rsp_data_in = mem_q;
         SRC_KEY: rsp_data_in = value_ff;
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status <= cmd.rsp_status;
         rsp_data   <= rsp_data_in;
         rsp_slot   <= cmd.rsp_slot_en ? slot_of(walk_ptr_ff) : '0;
         rsp_last   <= cmd.rsp_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status to the controller
   always_comb begin
      stat.kind      = kind_ff;
      stat.full      = (cnt_ff == CNT_W'(DEPTH));
      stat.empty     = (cnt_ff == '0);
      stat.hit       = (mem_q == value_ff);
      stat.walk_last = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) == {1'b0, limit};
      stat.rsp_free  = rsp_free;
   end

   // Checks
   `CQS_INVARIANT(a_cnt_range, cnt_ff <= CNT_W'(DEPTH), "fill count above depth")
   `CQS_INVARIANT(a_empty_ptrs, (cnt_ff != '0) || (head_ff == tail_ff), "empty ring, pointers differ")
   `CQS_ASSERT(a_no_enq_full, cmd.enq_write |-> (cnt_ff != CNT_W'(DEPTH)), "write into full ring")
   `CQS_ASSERT(a_no_deq_empty, cmd.deq |-> (cnt_ff != '0), "dequeue from empty ring")
   `CQS_ASSERT(a_load_free, cmd.rsp_load |-> rsp_free, "result overwritten before taken")

endmodule

`default_nettype wire

@@ rtl/core/circular_queue_with_search.sv @@
// Ring-buffer queue of signed 32-bit words with search and display.
// Request channel: req_valid, req_stall, req_kind, req_value; a request is taken
// when req_valid is high and req_stall low. The block takes one request at a time.
// Result channel: rsp_valid, rsp_stall, rsp_status, rsp_data, rsp_slot, rsp_last;
// rsp_last marks the final result of a request.
// Enqueue and dequeue: one result, loaded from the decide state once the output
// register is free. Empty or full cases likewise give one status result.
// Search: the walk starts at the head and compares one stored word per cycle
// through the single registered read port of the store; the result is loaded on
// the first match, or after the last held word on a miss.
// Display: one result per held word (at most eight), one per cycle while the
// receiver does not stall.
// A new request is taken in the cycle after the previous one has loaded its last
// result into the output register, so a waiting result does not hold off the next
// request. When the receiver stalls, the result holds and a walk waits to load.
// Reset (synchronous, active high) empties the queue at once; stored words
// are not cleared and no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_with_search
   import cqs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic        [1:0]        req_kind,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic             [1:0]        rsp_status,
   output logic signed      [DATA_W-1:0] rsp_data,
   output logic             [SLOT_W-1:0] rsp_slot,
   output logic                          rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   cqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, pointers and output register
   cqs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_slot   (rsp_slot),
      .rsp_last   (rsp_last),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import cqs_pkg::*;

   localparam int RANDOM_REQS    = 420;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 3 * DEPTH + 10;
   localparam int LONG_HOLD      = 150;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] value;
      logic [7:0]        gap;
      logic              drain;
   } queue_req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] data;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } queue_rsp_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic        [1:0]        req_kind  = KIND_ENQ;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic        [1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic        [SLOT_W-1:0] rsp_slot;
   logic                     rsp_last;

   // pending requests, expected results, counters
   queue_req_type     pending_reqs[$];
   queue_rsp_type     expected_rsps[$];
   logic [DATA_W-1:0] held_words[$];
   int                reqs_total    = 0;
   int                reqs_accepted = 0;
   int                rsps_seen     = 0;
   int                errors        = 0;
   int                gap_left      = 0;
   int                stall_left    = 0;
   int                hold_left     = 0;
   int                idle_cycles   = 0;

   // predictor state of the ring
   logic [DATA_W-1:0] ring_mem[DEPTH];
   logic [PTR_W-1:0]  ring_head  = '0;
   logic [PTR_W-1:0]  ring_tail  = '0;
   logic              ring_empty = 1'b1;

   circular_queue_with_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_slot   (rsp_slot),
      .rsp_last   (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
      ring_advance = PTR_W'((int'(p) + 1) % DEPTH);
   endfunction

   // expected results of one request; updates the ring state
   function automatic void predict_queue_op(input kind_type kind,
                                            input logic [DATA_W-1:0] value);
      int               held;
      int               shown;
      bit               found;
      logic [PTR_W-1:0] pos;
      queue_rsp_type    r;
      if (ring_empty) held = 0;
      else if (ring_tail > ring_head) held = int'(ring_tail) - int'(ring_head);
      else held = int'(ring_tail) + DEPTH - int'(ring_head);
      r = '{status: ST_OK, data: '0, slot: '0, last: 1'b1};
      if (kind == KIND_ENQ) begin
         if (held >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            ring_mem[ring_tail] = value;
            ring_tail = ring_advance(ring_tail);
            ring_empty = 1'b0;
         end
         expected_rsps.push_back(r);
      end else if (held == 0) begin
         r.status = ST_EMPTY;
         expected_rsps.push_back(r);
      end else begin
         case (kind)
            KIND_DEQ: begin
               r.data = ring_mem[ring_head];
               ring_head = ring_advance(ring_head);
               if (ring_head == ring_tail) ring_empty = 1'b1;
               expected_rsps.push_back(r);
            end
            KIND_SEARCH: begin
               found = 1'b0;
               pos = ring_head;
               for (int i = 0; i < held; i++) begin
                  if (!found && ring_mem[pos] == value) begin
                     found = 1'b1;
                     r.data = value;
                     r.slot = SLOT_W'(pos);
                  end
                  pos = ring_advance(pos);
               end
               if (!found) r.status = ST_NOTFOUND;
               expected_rsps.push_back(r);
            end
            default: begin
               // display shows at most SHOW_MAX words from the head
               shown = (held > SHOW_MAX) ? SHOW_MAX : held;
               pos = ring_head;
               for (int i = 0; i < shown; i++) begin
                  r.data = ring_mem[pos];
                  r.slot = SLOT_W'(pos);
                  r.last = (i == shown - 1);
                  expected_rsps.push_back(r);
                  pos = ring_advance(pos);
               end
            end
         endcase
      end
   endfunction

   // append a request; keep a rough list of held words for picking search keys
   task automatic add_request(input kind_type kind, input logic [DATA_W-1:0] value,
                              input int gap, input bit drain);
      queue_req_type q;
      q = '{kind: kind, value: value, gap: 8'(gap), drain: drain};
      pending_reqs.push_back(q);
      if (kind == KIND_ENQ && held_words.size() < DEPTH) held_words.push_back(value);
      if (kind == KIND_DEQ && held_words.size() > 0) void'(held_words.pop_front());
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: pick_word = 32'h7FFF_FFFF;
            1: pick_word = 32'h8000_0000;
            2: pick_word = '0;
            default: pick_word = '1;
         endcase
      end else if (r <= 3) begin
         pick_word = DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
      end else begin
         pick_word = $urandom;
      end
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      queue_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_kind  <= KIND_ENQ;
         req_value <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_queue_op(kind_type'(req_kind), req_value);
            reqs_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain || expected_rsps.size() == 0)) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_kind  <= nxt.kind;
               req_value <= nxt.value;
               gap_left = int'(nxt.gap);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin : watch_rsp
      queue_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: status %0d data %h slot %0d last %0b",
                        $time, rsp_status, rsp_data, rsp_slot, rsp_last);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_data !== want.data) begin
                  errors++;
                  $display("%0t: data mismatch: expected %h, actual %h",
                           $time, want.data, rsp_data);
               end
               if (rsp_slot !== want.slot) begin
                  errors++;
                  $display("%0t: slot mismatch: expected %0d, actual %0d",
                           $time, want.slot, rsp_slot);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last);
               end
            end
            // one long hold so the block backs up onto its request side
            if (rsps_seen == 60) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ((rsps_seen / 80) % 4 == 3) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int         r;
      int         mode;
      int         gap;
      kind_type   kind;
      logic [DATA_W-1:0] value;

      // empty queue: dequeue, search and display
      add_request(KIND_DEQ,     '0, $urandom_range(0, 2), 1'b0);
      add_request(KIND_SEARCH,  '1, $urandom_range(0, 2), 1'b0);
      add_request(KIND_DISPLAY, '0, $urandom_range(0, 2), 1'b0);
      // extremes of the word
      add_request(KIND_ENQ, 32'h7FFF_FFFF, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'h8000_0000, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, '0,            $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, '1,            $urandom_range(0, 2), 1'b0);
      // hit, hit, miss
      add_request(KIND_SEARCH, '1,            $urandom_range(0, 2), 1'b0);
      add_request(KIND_SEARCH, 32'h8000_0000, $urandom_range(0, 2), 1'b0);
      add_request(KIND_SEARCH, 32'd12345,     $urandom_range(0, 2), 1'b0);
      // fill up, with a second zero to check first-match
      add_request(KIND_ENQ, 32'd5, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, '0,    $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'd7, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'd8, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'd99, $urandom_range(0, 2), 1'b0);
      add_request(KIND_DISPLAY, '0, $urandom_range(0, 2), 1'b0);
      add_request(KIND_SEARCH, '0,    $urandom_range(0, 2), 1'b0);
      add_request(KIND_SEARCH, 32'd8, $urandom_range(0, 2), 1'b0);
      // move the head round, then wrap the tail
      add_request(KIND_DEQ, '0, $urandom_range(0, 2), 1'b0);
      add_request(KIND_DEQ, '0, $urandom_range(0, 2), 1'b0);
      add_request(KIND_DEQ, '0, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'h5A5A_A5A5, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'hA5A5_5A5A, $urandom_range(0, 2), 1'b0);
      add_request(KIND_ENQ, 32'h0000_0001, $urandom_range(0, 2), 1'b0);
      add_request(KIND_DISPLAY, '0, $urandom_range(0, 2), 1'b0);

      // random part: phases leaning toward fill, drain, or balanced
      for (int i = 0; i < RANDOM_REQS; i++) begin
         mode = (i / 40) % 3;
         r = $urandom_range(0, 99);
         if (mode == 0)
            kind = (r < 55) ? KIND_ENQ : (r < 70) ? KIND_DEQ :
                   (r < 88) ? KIND_SEARCH : KIND_DISPLAY;
         else if (mode == 1)
            kind = (r < 20) ? KIND_ENQ : (r < 65) ? KIND_DEQ :
                   (r < 85) ? KIND_SEARCH : KIND_DISPLAY;
         else
            kind = (r < 35) ? KIND_ENQ : (r < 60) ? KIND_DEQ :
                   (r < 85) ? KIND_SEARCH : KIND_DISPLAY;
         if (kind == KIND_SEARCH && held_words.size() > 0 && $urandom_range(0, 9) < 6)
            value = held_words[$urandom_range(0, held_words.size() - 1)];
         else
            value = pick_word();
         // back-to-back stretches with no gaps, else mostly none or short, a few long
         if ((i / 50) % 4 == 1) begin
            gap = 0;
         end else begin
            r = $urandom_range(0, 99);
            gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
         add_request(kind, value, gap, (i % 70) == 0);
      end
      reqs_total = pending_reqs.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (reqs_accepted < reqs_total) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
